>>> rtl/sopt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority order table package
// Request, status and register codes and the sequencer state type.
// ----------------------------------------------------------------------------
package sopt_pkg;

	// Request codes carried on req_type.
	typedef enum logic [1:0] {
		REQ_CREATE    = 2'd0,
		REQ_SET_Z     = 2'd1,
		REQ_SET_LAYER = 2'd2,
		REQ_READ      = 2'd3
	} req_e_t;

	// Status codes returned with each result.
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_UNKNOWN_ID = 2'd2,
		ST_RANGE      = 2'd3
	} status_e_t;

	// Register index of normal_layer (taken from paddr bit 2).
	localparam logic       REG_NORMAL_LAYER   = 1'b0;
	localparam logic [2:0] NORMAL_LAYER_RESET = 3'd1;

	// Sequencer states, one-hot.
	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_KEY_LD  = 11'b000_0000_0010,
		S_BS_ORD  = 11'b000_0000_0100,
		S_BS_KEY  = 11'b000_0000_1000,
		S_BS_CMP  = 11'b000_0001_0000,
		S_KEY_WR  = 11'b000_0010_0000,
		S_NB_ORD  = 11'b000_0100_0000,
		S_NB_KEY  = 11'b000_1000_0000,
		S_NB_CMP  = 11'b001_0000_0000,
		S_FIN     = 11'b010_0000_0000,
		S_RD_DATA = 11'b100_0000_0000
	} state_e_t;

endpackage

>>> rtl/sopt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and holds until
// the next read.
// ----------------------------------------------------------------------------
module sopt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/sopt_cmp.sv
// ----------------------------------------------------------------------------
// Sort key comparator
// Tells whether entry a sorts strictly ahead of entry b by layer, then signed
// z index, then id.
// ----------------------------------------------------------------------------
module sopt_cmp #(
	parameter int LW = 3,
	parameter int ZW = 16,
	parameter int IW = 6
) (
	input  logic                 [LW-1:0] a_layer,
	input  logic signed          [ZW-1:0] a_z,
	input  logic                 [IW-1:0] a_id,
	input  logic                 [LW-1:0] b_layer,
	input  logic signed          [ZW-1:0] b_z,
	input  logic                 [IW-1:0] b_id,
	output logic                          precedes
);

	always_comb begin
		if (a_layer != b_layer) begin
			precedes = a_layer < b_layer;
		end else if (a_z != b_z) begin
			precedes = a_z < b_z;
		end else begin
			precedes = a_id < b_id;
		end
	end

endmodule

>>> rtl/sorted_priority_order_table.sv
// ----------------------------------------------------------------------------
// Sorted priority order table
// Keeps entry ids sorted by (layer, z index, id) using a binary search and
// a one-step-at-a-time shift, all driven through one shared key comparator.
// ----------------------------------------------------------------------------
// A rejected request or a read of position 0 finishes from idle; any other read
// passes through S_RD_DATA. A create shifts the new entry into place; a set searches
// for the entry, writes its new key in S_KEY_WR, then shifts it into place.
// Probe and shift steps each run ORD, KEY and CMP states; the RAM reads are registered.
// Throughput: one request at a time; busy stays high until the edge that raises done.
// Reset: arst_n clears the sequencer, sets the count and normal_layer to one; no stall.
// ----------------------------------------------------------------------------
module sorted_priority_order_table import sopt_pkg::*; #(
	parameter int MAX_ENTRIES = 64,
	parameter int LAYER_COUNT = 8,
	parameter int ZINDEX_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// Request channel
	input  logic               start,
	output logic               busy,
	input  logic        [1:0]  req_type,
	input  logic        [5:0]  entry_id,
	input  logic signed [15:0] key_value,
	input  logic        [5:0]  position,
	// Result channel
	output logic               done,
	output logic        [5:0]  result_value,
	output logic        [1:0]  status,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [2:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);

	// Id and position width, count width (holds MAX_ENTRIES itself), key widths.
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = $clog2(LAYER_COUNT);
	localparam int ZW = ZINDEX_BITS;
	localparam int KW = LW + ZW;
	// Common width for comparing the 6-bit request fields against the count.
	localparam int XW = (CW > 6) ? CW : 6;

	localparam logic        [3:0]  LAYER_MAX = 4'(LAYER_COUNT - 1);
	localparam logic signed [32:0] ZHI       = 33'((longint'(1) << (ZW - 1)) - 1);
	localparam logic signed [32:0] ZLO       = -ZHI - 33'sd1;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [2:0] normal_layer_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_NORMAL_LAYER);
	assign prdata = (paddr[2] == REG_NORMAL_LAYER) ? 32'(normal_layer_q) : 32'd0;

	// ------------------------------------------------------------------
	// Sequencer registers
	// ------------------------------------------------------------------
	state_e_t             state_q;
	logic        [CW-1:0] count_q;
	logic        [1:0]    req_q;
	logic        [IW-1:0] tgt_id_q;
	logic        [LW-1:0] tgt_layer_q;
	logic signed [ZW-1:0] tgt_z_q;
	logic        [LW-1:0] new_layer_q;
	logic signed [ZW-1:0] new_z_q;
	logic        [CW-1:0] lo_q;
	logic        [CW-1:0] hi_q;
	logic        [CW-1:0] mid_q;
	logic        [IW-1:0] idx_q;
	logic                 down_q;
	logic                 moved_q;
	logic                 done_q;
	logic        [5:0]    result_q;
	status_e_t            status_q;

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;

	// ------------------------------------------------------------------
	// Memories: key table holds {layer, z index} per id, order table holds
	// the id at each sorted position.
	// ------------------------------------------------------------------
	logic          key_we, key_re;
	logic [IW-1:0] key_waddr, key_raddr;
	logic [KW-1:0] key_wdata, key_rdata;
	logic          ord_we, ord_re;
	logic [IW-1:0] ord_waddr, ord_raddr;
	logic [IW-1:0] ord_wdata, ord_rdata;

	sopt_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	sopt_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_ord_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.re    (ord_re),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	// ------------------------------------------------------------------
	// Request decode and key saturation
	// ------------------------------------------------------------------
	logic                 accept;
	logic                 full;
	logic                 id_ok;
	logic                 pos_ok;
	logic        [LW-1:0] norm_layer_sat;
	logic        [LW-1:0] key_layer_sat;
	logic signed [32:0]   key_ext;
	logic signed [32:0]   key_sat;

	assign accept = start & ~busy;
	assign full   = (count_q == CW'(MAX_ENTRIES));
	// Entry 0 is the sentinel and can never be moved.
	assign id_ok  = (entry_id != 6'd0) && (XW'(entry_id) < XW'(count_q));
	assign pos_ok = (XW'(position) < XW'(count_q));

	assign norm_layer_sat = ({1'b0, normal_layer_q} > LAYER_MAX) ? LW'(LAYER_MAX) :
		LW'({1'b0, normal_layer_q});
	assign key_layer_sat  = (key_value[3:0] > LAYER_MAX) ? LW'(LAYER_MAX) :
		LW'(key_value[3:0]);

	// Saturate the incoming z index to the signed range of the table.
	assign key_ext = 33'(key_value);
	always_comb begin
		if (key_ext > ZHI) begin
			key_sat = ZHI;
		end else if (key_ext < ZLO) begin
			key_sat = ZLO;
		end else begin
			key_sat = key_ext;
		end
	end

	// ------------------------------------------------------------------
	// Shared comparator. The other entry comes straight from the RAM read
	// registers; the operands swap when checking a move toward position 1.
	// ------------------------------------------------------------------
	logic                 swap;
	logic        [LW-1:0] oth_layer;
	logic signed [ZW-1:0] oth_z;
	logic        [LW-1:0] a_layer, b_layer;
	logic signed [ZW-1:0] a_z, b_z;
	logic        [IW-1:0] a_id, b_id;
	logic                 precedes;

	assign oth_layer = key_rdata[KW-1:ZW];
	assign oth_z     = $signed(key_rdata[ZW-1:0]);
	assign swap      = (state_q == S_NB_CMP) && down_q;

	assign a_layer = swap ? tgt_layer_q : oth_layer;
	assign a_z     = swap ? tgt_z_q     : oth_z;
	assign a_id    = swap ? tgt_id_q    : ord_rdata;
	assign b_layer = swap ? oth_layer   : tgt_layer_q;
	assign b_z     = swap ? oth_z       : tgt_z_q;
	assign b_id    = swap ? ord_rdata   : tgt_id_q;

	sopt_cmp #(.LW(LW), .ZW(ZW), .IW(IW)) u_cmp (
		.a_layer  (a_layer),
		.a_z      (a_z),
		.a_id     (a_id),
		.b_layer  (b_layer),
		.b_z      (b_z),
		.b_id     (b_id),
		.precedes (precedes)
	);

	// ------------------------------------------------------------------
	// Search and shift helpers
	// ------------------------------------------------------------------
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic          bs_open;
	logic          dn_ok;
	logic          up_ok;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign bs_open = (lo_q <= hi_q);
	// A neighbor exists below (toward position 1) or above (toward the end).
	assign dn_ok   = (idx_q > IW'(1));
	assign up_ok   = ((CW'(idx_q) + CW'(1)) < count_q);

	// ------------------------------------------------------------------
	// RAM port control
	// ------------------------------------------------------------------
	always_comb begin
		key_we    = 1'b0;
		key_waddr = tgt_id_q;
		key_wdata = {tgt_layer_q, tgt_z_q};
		key_re    = 1'b0;
		key_raddr = ord_rdata;
		ord_we    = 1'b0;
		ord_waddr = idx_q;
		ord_wdata = tgt_id_q;
		ord_re    = 1'b0;
		ord_raddr = IW'(mid);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_CREATE: begin
							// The new id takes the next free slot of the key table.
							key_we    = ~full;
							key_waddr = IW'(count_q);
							key_wdata = {norm_layer_sat, {ZW{1'b0}}};
						end
						REQ_SET_Z, REQ_SET_LAYER: begin
							key_re    = id_ok;
							key_raddr = IW'(entry_id);
						end
						REQ_READ: begin
							ord_re    = pos_ok && (position != 6'd0);
							ord_raddr = IW'(position);
						end
						default: begin
						end
					endcase
				end
			end
			S_BS_ORD: begin
				ord_re = bs_open;
			end
			S_BS_KEY: begin
				key_re = (ord_rdata != tgt_id_q);
			end
			S_KEY_WR: begin
				key_we    = 1'b1;
				key_wdata = {new_layer_q, new_z_q};
			end
			S_NB_ORD: begin
				if (down_q) begin
					ord_re    = dn_ok;
					ord_raddr = idx_q - IW'(1);
				end else begin
					ord_re    = up_ok;
					ord_raddr = idx_q + IW'(1);
				end
			end
			S_NB_KEY: begin
				key_re = 1'b1;
			end
			S_NB_CMP: begin
				// Neighbor takes this slot and the entry moves one step on.
				ord_we    = precedes;
				ord_wdata = ord_rdata;
			end
			S_FIN: begin
				ord_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_layer_q <= NORMAL_LAYER_RESET;
			state_q        <= S_IDLE;
			count_q        <= CW'(1);
			req_q          <= REQ_CREATE;
			tgt_id_q       <= '0;
			tgt_layer_q    <= '0;
			tgt_z_q        <= '0;
			new_layer_q    <= '0;
			new_z_q        <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
			mid_q          <= '0;
			idx_q          <= '0;
			down_q         <= 1'b0;
			moved_q        <= 1'b0;
			done_q         <= 1'b0;
			result_q       <= '0;
			status_q       <= ST_OK;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				normal_layer_q <= pwdata[2:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req_type;
						unique case (req_type)
							REQ_CREATE: begin
								if (full) begin
									done_q   <= 1'b1;
									result_q <= 6'd0;
									status_q <= ST_FULL;
								end else begin
									tgt_id_q    <= IW'(count_q);
									tgt_layer_q <= norm_layer_sat;
									tgt_z_q     <= '0;
									idx_q       <= IW'(count_q);
									count_q     <= count_q + CW'(1);
									down_q      <= 1'b1;
									moved_q     <= 1'b0;
									state_q     <= S_NB_ORD;
								end
							end
							REQ_SET_Z, REQ_SET_LAYER: begin
								if (!id_ok) begin
									done_q   <= 1'b1;
									result_q <= 6'd0;
									status_q <= ST_UNKNOWN_ID;
								end else begin
									tgt_id_q    <= IW'(entry_id);
									new_layer_q <= key_layer_sat;
									new_z_q     <= $signed(ZW'(key_sat));
									lo_q        <= CW'(1);
									hi_q        <= count_q - CW'(1);
									state_q     <= S_KEY_LD;
								end
							end
							REQ_READ: begin
								if (!pos_ok) begin
									done_q   <= 1'b1;
									result_q <= 6'd0;
									status_q <= ST_RANGE;
								end else if (position == 6'd0) begin
									// The sentinel always sits at position 0.
									done_q   <= 1'b1;
									result_q <= 6'd0;
									status_q <= ST_OK;
								end else begin
									state_q <= S_RD_DATA;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_KEY_LD: begin
					// The search runs on the old key; the half of the new key
					// that the request leaves alone is copied from it.
					tgt_layer_q <= oth_layer;
					tgt_z_q     <= oth_z;
					if (req_q == REQ_SET_Z) begin
						new_layer_q <= oth_layer;
					end else begin
						new_z_q <= oth_z;
					end
					state_q <= S_BS_ORD;
				end
				S_BS_ORD: begin
					if (bs_open) begin
						mid_q   <= mid;
						state_q <= S_BS_KEY;
					end else begin
						done_q   <= 1'b1;
						result_q <= 6'd0;
						status_q <= ST_UNKNOWN_ID;
						state_q  <= S_IDLE;
					end
				end
				S_BS_KEY: begin
					if (ord_rdata == tgt_id_q) begin
						idx_q   <= IW'(mid_q);
						state_q <= S_KEY_WR;
					end else begin
						state_q <= S_BS_CMP;
					end
				end
				S_BS_CMP: begin
					if (precedes) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q - CW'(1);
					end
					state_q <= S_BS_ORD;
				end
				S_KEY_WR: begin
					tgt_layer_q <= new_layer_q;
					tgt_z_q     <= new_z_q;
					down_q      <= 1'b1;
					moved_q     <= 1'b0;
					state_q     <= S_NB_ORD;
				end
				S_NB_ORD: begin
					if (down_q && dn_ok) begin
						state_q <= S_NB_KEY;
					end else if (down_q && !moved_q) begin
						// Nothing below to pass: try moving toward the end.
						down_q <= 1'b0;
					end else if (!down_q && up_ok) begin
						state_q <= S_NB_KEY;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_NB_KEY: begin
					state_q <= S_NB_CMP;
				end
				S_NB_CMP: begin
					if (precedes) begin
						idx_q   <= down_q ? (idx_q - IW'(1)) : (idx_q + IW'(1));
						moved_q <= 1'b1;
						state_q <= S_NB_ORD;
					end else if (down_q && !moved_q) begin
						down_q  <= 1'b0;
						state_q <= S_NB_ORD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q   <= 1'b1;
					result_q <= (req_q == REQ_CREATE) ? 6'(tgt_id_q) : 6'(idx_q);
					status_q <= ST_OK;
					state_q  <= S_IDLE;
				end
				S_RD_DATA: begin
					done_q   <= 1'b1;
					result_q <= 6'(ord_rdata);
					status_q <= ST_OK;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(1)) && (count_q <= CW'(MAX_ENTRIES)))
		else $error("entry count left its range");

	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result transfer");

	a_ok_result_live: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == ST_OK)) |-> (XW'(result_q) < XW'(count_q)))
		else $error("successful result points past the live entries");

	a_settle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_NB_ORD) || (state_q == S_NB_KEY) || (state_q == S_NB_CMP) ||
		 (state_q == S_FIN)) |-> ((idx_q >= IW'(1)) && (CW'(idx_q) < count_q)))
		else $error("shift position outside the live entries");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_BS_KEY) || (state_q == S_BS_CMP)) |->
		((mid_q >= CW'(1)) && (mid_q < count_q)))
		else $error("search probe outside the live entries");

endmodule
